@@ sv/ccns_pkg.sv @@
// Shared codes and helpers for the consistency class node selector.
// No dependencies; used by ccns_mod and the top level.
package ccns_pkg;

	localparam int KEY_W   = 32;
	localparam int CLS_W   = 2;
	localparam int NODE_W  = 4;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 8;

	localparam logic [2:0] K_ADD    = 3'd0;
	localparam logic [2:0] K_UP     = 3'd1;
	localparam logic [2:0] K_ASSIGN = 3'd2;
	localparam logic [2:0] K_GET    = 3'd3;
	localparam logic [2:0] K_GETANY = 3'd4;
	localparam logic [2:0] K_DOWN   = 3'd5;

	localparam logic [2:0] C_STRONG = 3'd0;
	localparam logic [2:0] C_HASHED = 3'd1;
	localparam logic [2:0] C_NONE   = 3'd3;
	localparam logic [2:0] C_LAST   = 3'd3;

	localparam logic [2:0] E_OK     = 3'd0;
	localparam logic [2:0] E_NODE   = 3'd1;
	localparam logic [2:0] E_CLASS  = 3'd2;
	localparam logic [2:0] E_UNK    = 3'd3;
	localparam logic [2:0] E_DOWN   = 3'd4;
	localparam logic [2:0] E_ASGN   = 3'd5;
	localparam logic [2:0] E_TAKEN  = 3'd6;
	localparam logic [2:0] E_NONODE = 3'd7;

	function automatic logic [OUT_W-1:0] pack_res(input logic ok, input logic [NODE_W-1:0] ch,
			input logic [2:0] err);
		pack_res = {err, ch, ok};
	endfunction

endpackage

@@ sv/ccns_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies; holds the class lists.
module ccns_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/ccns_mod.sv @@
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on ccns_pkg for the key width.
module ccns_mod #(
	parameter int AW = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ccns_pkg::KEY_W-1:0] dividend,
	input  logic [AW-1:0]            divisor,
	output logic                     done,
	output logic [AW-1:0]            rem
);
	import ccns_pkg::*;

	localparam int CW = $clog2(KEY_W);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [KEY_W-1:0] dvd_q;
	logic [AW:0]   rem_q;
	logic [AW:0]   shifted;
	logic [AW:0]   nxt;

	always_comb begin
		shifted = {rem_q[AW-1:0], dvd_q[KEY_W-1]};
		nxt = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(KEY_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[AW-1:0];
endmodule

@@ sv/consistency_class_node_selector.sv @@
// Top level of the consistency class node selector: status bits, sequencer, list RAM.
// Depends on ccns_pkg, ccns_ram and ccns_mod.
//
// One request at a time; every request gives exactly one result. Add, up, down of a handshaking
// node and all rejected requests finish in the execute state. Strong get reads the list head,
// hashed get reads the entry chosen by the bit-serial remainder unit, eventual/none get reads the
// head and rotates it to the tail, assign shifts the list up and writes the node at the head, and
// down of an available node removes it from each class it belongs to. The list RAM moves entries
// through its single read and single write port. A pending result in the output register does not
// block the next request from being taken once that result is taken.
module consistency_class_node_selector #(
	parameter int NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // kind[2:0], node[6:3], consistency[9:7], key[41:10], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // ok[0], chosen_node[4:1], error_code[7:5]
);
	import ccns_pkg::*;

	localparam int NIDX = (NODES < 16) ? NODES : 16;
	localparam int AW   = $clog2(NIDX);
	localparam int LD   = 2 ** AW;

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MOD, S_RD, S_WR, S_FIN, S_DN} state_t;
	typedef enum logic [1:0] {MV_PICK, MV_SHR, MV_SHL, MV_CMP} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [2:0]        kind_q;
	logic [NODE_W-1:0] node_q;
	logic [2:0]        cls_q;
	logic [KEY_W-1:0]  key_q;

	logic [NIDX-1:0]       known_q, hs_q, av_q;
	logic [NIDX-1:0][3:0]  member_q;
	logic [3:0][AW-1:0]    len_q;
	logic [CLS_W-1:0]      c_q;
	logic [AW-1:0]         r_q, w_q;
	logic [NODE_W-1:0]     pick_q;
	logic [3:0]            mask_q;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	logic [AW-1:0]     ni;
	logic              nvalid;
	logic [2:0]        gcls;
	logic [AW-1:0]     cur_len;
	logic [CLS_W-1:0]  low_c;
	logic              keep;
	logic              mod_start, mod_done;
	logic [AW-1:0]     mod_rem;
	logic              ram_we;
	logic [AW-1:0]     widx;
	logic [NODE_W-1:0] ram_wdata, ram_rdata;

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		ni      = node_q[AW-1:0];
		nvalid  = (node_q != '0) && ({28'd0, node_q} < 32'(NODES));
		gcls    = (kind_q == K_GETANY) ? C_NONE : cls_q;
		cur_len = len_q[c_q];
		keep    = (ram_rdata != node_q);
		low_c   = mask_q[0] ? 2'd0 : mask_q[1] ? 2'd1 : mask_q[2] ? 2'd2 : 2'd3;
		mod_start = (state_q == S_EXEC) && (kind_q == K_GET) && (cls_q == C_HASHED)
			&& (len_q[C_HASHED[CLS_W-1:0]] != '0);
		ram_we    = 1'b0;
		widx      = r_q;
		ram_wdata = ram_rdata;
		case (state_q)
			S_WR: begin
				case (mode_q)
					MV_SHR: begin
						ram_we = 1'b1;
						widx   = r_q + AW'(1);
					end
					MV_SHL: begin
						ram_we = 1'b1;
						widx   = r_q - AW'(1);
					end
					MV_CMP: begin
						ram_we = keep;
						widx   = w_q;
					end
					default: ram_we = 1'b0;
				endcase
			end
			S_FIN: begin
				ram_we = 1'b1;
				if (mode_q == MV_SHR) begin
					widx      = '0;
					ram_wdata = node_q;
				end else begin
					widx      = cur_len - AW'(1);
					ram_wdata = pick_q;
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	ccns_ram #(.WIDTH(NODE_W), .DEPTH(4 * LD)) u_lists (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({c_q, widx}),
		.wdata (ram_wdata),
		.raddr ({c_q, r_q}),
		.rdata (ram_rdata)
	);

	ccns_mod #(.AW(AW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (key_q),
		.divisor  (len_q[C_HASHED[CLS_W-1:0]]),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tdata[2:0];
			node_q <= s_tdata[6:3];
			cls_q  <= s_tdata[9:7];
			key_q  <= s_tdata[41:10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MV_PICK;
			known_q    <= '0;
			hs_q       <= '0;
			av_q       <= '0;
			member_q   <= '0;
			len_q      <= '0;
			c_q        <= '0;
			r_q        <= '0;
			w_q        <= '0;
			pick_q     <= '0;
			mask_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q    <= S_IDLE;
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= pack_res(1'b1, '0, E_OK);
					if (kind_q == K_GET || kind_q == K_GETANY) begin
						c_q <= gcls[CLS_W-1:0];
						if (gcls > C_LAST) begin
							m_tdata_q <= pack_res(1'b0, '0, E_CLASS);
						end else if (len_q[gcls[CLS_W-1:0]] == '0) begin
							m_tdata_q <= pack_res(1'b0, '0, E_NONODE);
						end else begin
							m_tvalid_q <= 1'b0;
							mode_q     <= MV_PICK;
							r_q        <= '0;
							state_q    <= (gcls == C_HASHED) ? S_MOD : S_RD;
						end
					end else if (kind_q > K_DOWN) begin
						m_tdata_q <= pack_res(1'b0, '0, E_OK);
					end else if (!nvalid) begin
						m_tdata_q <= pack_res(1'b0, '0, E_NODE);
					end else begin
						case (kind_q)
							K_ADD: begin
								if (!av_q[ni]) begin
									known_q[ni] <= 1'b1;
									hs_q[ni]    <= 1'b1;
								end
							end
							K_UP: begin
								if (!known_q[ni]) begin
									m_tdata_q <= pack_res(1'b0, '0, E_UNK);
								end else if (av_q[ni]) begin
									av_q[ni] <= 1'b1;
								end else if (hs_q[ni]) begin
									hs_q[ni] <= 1'b0;
									av_q[ni] <= 1'b1;
								end else begin
									m_tdata_q <= pack_res(1'b0, '0, E_DOWN);
								end
							end
							K_ASSIGN: begin
								c_q <= cls_q[CLS_W-1:0];
								if (cls_q > C_LAST) begin
									m_tdata_q <= pack_res(1'b0, '0, E_CLASS);
								end else if (!known_q[ni]) begin
									m_tdata_q <= pack_res(1'b0, '0, E_UNK);
								end else if (!av_q[ni]) begin
									m_tdata_q <= pack_res(1'b0, '0, E_DOWN);
								end else if (member_q[ni][cls_q[CLS_W-1:0]]) begin
									m_tdata_q <= pack_res(1'b0, '0, E_ASGN);
								end else if (cls_q == C_STRONG
										&& len_q[C_STRONG[CLS_W-1:0]] != '0) begin
									m_tdata_q <= pack_res(1'b0, '0, E_TAKEN);
								end else begin
									m_tvalid_q <= 1'b0;
									mode_q     <= MV_SHR;
									r_q        <= len_q[cls_q[CLS_W-1:0]] - AW'(1);
									state_q    <= (len_q[cls_q[CLS_W-1:0]] == '0) ? S_FIN : S_RD;
								end
							end
							K_DOWN: begin
								if (!known_q[ni]) begin
									m_tdata_q <= pack_res(1'b0, '0, E_UNK);
								end else if (hs_q[ni]) begin
									hs_q[ni] <= 1'b0;
								end else if (av_q[ni]) begin
									av_q[ni]   <= 1'b0;
									mask_q     <= member_q[ni];
									m_tvalid_q <= 1'b0;
									state_q    <= S_DN;
								end
							end
							default: m_tdata_q <= pack_res(1'b0, '0, E_OK);
						endcase
					end
				end
				S_MOD: begin
					if (mod_done) begin
						r_q     <= mod_rem;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					case (mode_q)
						MV_PICK: begin
							if (c_q[1] && cur_len != AW'(1)) begin
								pick_q  <= ram_rdata;
								r_q     <= AW'(1);
								mode_q  <= MV_SHL;
								state_q <= S_RD;
							end else begin
								m_tvalid_q <= 1'b1;
								m_tdata_q  <= pack_res(1'b1, ram_rdata, E_OK);
								state_q    <= S_IDLE;
							end
						end
						MV_SHR: begin
							r_q     <= r_q - AW'(1);
							state_q <= (r_q == '0) ? S_FIN : S_RD;
						end
						MV_SHL: begin
							r_q     <= r_q + AW'(1);
							state_q <= (r_q == cur_len - AW'(1)) ? S_FIN : S_RD;
						end
						MV_CMP: begin
							if (keep) begin
								w_q <= w_q + AW'(1);
							end
							r_q <= r_q + AW'(1);
							if (r_q == cur_len - AW'(1)) begin
								len_q[c_q] <= w_q + AW'(keep);
								state_q    <= S_DN;
							end else begin
								state_q <= S_RD;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_FIN: begin
					m_tvalid_q <= 1'b1;
					state_q    <= S_IDLE;
					if (mode_q == MV_SHR) begin
						len_q[c_q]         <= cur_len + AW'(1);
						member_q[ni][c_q]  <= 1'b1;
						m_tdata_q          <= pack_res(1'b1, '0, E_OK);
					end else begin
						m_tdata_q <= pack_res(1'b1, pick_q, E_OK);
					end
				end
				S_DN: begin
					if (mask_q == '0) begin
						member_q[ni] <= '0;
						m_tvalid_q   <= 1'b1;
						m_tdata_q    <= pack_res(1'b1, '0, E_OK);
						state_q      <= S_IDLE;
					end else begin
						c_q           <= low_c;
						mask_q[low_c] <= 1'b0;
						r_q           <= '0;
						w_q           <= '0;
						mode_q        <= MV_CMP;
						state_q       <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
